### hdl/jadt_pkg.sv
// jadt_pkg: shared constants, codes and control types of the job table
// used by the controller, datapath and top level of the job admission and dispatch table
package jadt_pkg;

   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int IDENT_BITS = 16;
   localparam int WAIT_DEPTH = 16;
   localparam int CNT_BITS   = 5;
   localparam int CFG_BITS   = 2;

   // request kinds
   localparam logic [2:0] REQ_SUBMIT   = 3'd0;
   localparam logic [2:0] REQ_CANCEL   = 3'd1;
   localparam logic [2:0] REQ_DISPATCH = 3'd2;
   localparam logic [2:0] REQ_FINISH   = 3'd3;
   localparam logic [2:0] REQ_TAKE     = 3'd4;
   localparam logic [2:0] REQ_STATUS   = 3'd5;
   localparam logic [2:0] REQ_TICK     = 3'd6;

   // job states
   localparam logic [3:0] ST_QUEUED     = 4'd0;
   localparam logic [3:0] ST_RUNNING    = 4'd1;
   localparam logic [3:0] ST_CANCELLING = 4'd2;
   localparam logic [3:0] ST_COMPLETED  = 4'd3;
   localparam logic [3:0] ST_CANCELLED  = 4'd4;
   localparam logic [3:0] ST_DEADLINE   = 4'd5;
   localparam logic [3:0] ST_FAILED     = 4'd8;

   // answer codes
   localparam logic [2:0] RC_OK         = 3'd0;
   localparam logic [2:0] RC_INVALID    = 3'd1;
   localparam logic [2:0] RC_WAIT_FULL  = 3'd2;
   localparam logic [2:0] RC_TABLE_FULL = 3'd3;
   localparam logic [2:0] RC_IDS_OUT    = 3'd4;
   localparam logic [2:0] RC_MISMATCH   = 3'd5;
   localparam logic [2:0] RC_REFUSED    = 3'd6;

   // coalescing modes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_JOIN  = 2'd1;
   localparam logic [1:0] MODE_SUPER = 2'd2;
   localparam logic [1:0] MODE_BAD   = 2'd3;

   // register indexes and reset values
   localparam logic [CFG_BITS-1:0] CSR_RUN_LIMIT  = 2'd0;
   localparam logic [CFG_BITS-1:0] CSR_WAIT_LIMIT = 2'd1;
   localparam logic [CFG_BITS-1:0] CSR_TIMEOUT    = 2'd2;
   localparam logic [CNT_BITS-1:0] RST_RUN_LIMIT  = 5'd1;
   localparam logic [CNT_BITS-1:0] RST_WAIT_LIMIT = 5'd16;
   localparam logic [31:0]         RST_TIMEOUT    = 32'd300000;

   // datapath phases commanded by the controller
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LOAD   = 3'd1;
   localparam logic [2:0] PH_SCAN   = 3'd2;
   localparam logic [2:0] PH_DECIDE = 3'd3;
   localparam logic [2:0] PH_OWNER  = 3'd4;
   localparam logic [2:0] PH_CREATE = 3'd5;
   localparam logic [2:0] PH_ACT    = 3'd6;
   localparam logic [2:0] PH_EMIT   = 3'd7;

   typedef struct packed {
      logic [2:0]           phase;
      logic [SLOT_BITS-1:0] scan_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } ctl_stat_type;

   function automatic logic is_terminal(input logic [3:0] s);
      return (s >= ST_COMPLETED) && (s <= ST_FAILED);
   endfunction

endpackage

### hdl/jadt_chan_if.sv
// jadt_chan_if: valid/ready channels for request and response words
// depends on nothing but the field widths of the job table
interface jadt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] now_time;
   logic [15:0] target_ident;
   logic [7:0]  op_code;
   logic [1:0]  merge_mode;
   logic [31:0] merge_key;
   logic [31:0] data_digest;
   logic        isolated_ok;
   logic [31:0] due_time;
   logic [3:0]  worker_outcome;

   modport source (output valid, req_type, now_time, target_ident, op_code, merge_mode,
                   merge_key, data_digest, isolated_ok, due_time, worker_outcome,
                   input ready);
   modport sink (input valid, req_type, now_time, target_ident, op_code, merge_mode,
                 merge_key, data_digest, isolated_ok, due_time, worker_outcome,
                 output ready);
endinterface

interface jadt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status_code;
   logic [15:0] result_ident;
   logic [3:0]  job_state;
   logic        cancel_flag;
   logic [7:0]  out_op_code;
   logic [31:0] out_merge_key;
   logic [31:0] out_digest;
   logic [31:0] out_due_time;

   modport source (output valid, status_code, result_ident, job_state, cancel_flag,
                   out_op_code, out_merge_key, out_digest, out_due_time, input ready);
   modport sink (input valid, status_code, result_ident, job_state, cancel_flag,
                 out_op_code, out_merge_key, out_digest, out_due_time, output ready);
endinterface

### hdl/jadt_ctrl.sv
// jadt_ctrl: sequencer of the job table, one request at a time
// depends on jadt_pkg for phase codes and command/status types
module jadt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jadt_pkg::ctl_stat_type stat,
   output jadt_pkg::ctl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_OWNER  = 3'd3;
   localparam logic [2:0] S_CREATE = 3'd4;
   localparam logic [2:0] S_ACT    = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   logic [2:0]                     state_ff, state_in;
   logic [jadt_pkg::SLOT_BITS-1:0] idx_ff, idx_in;

   // next state and phase command
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd.phase    = jadt_pkg::PH_IDLE;
      cmd.scan_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.phase = jadt_pkg::PH_LOAD;
               idx_in    = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.phase = jadt_pkg::PH_SCAN;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == jadt_pkg::SLOT_BITS'(jadt_pkg::SLOTS - 1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.phase = jadt_pkg::PH_DECIDE;
            state_in  = S_OWNER;
         end
         S_OWNER: begin
            cmd.phase = jadt_pkg::PH_OWNER;
            state_in  = S_CREATE;
         end
         S_CREATE: begin
            cmd.phase = jadt_pkg::PH_CREATE;
            state_in  = S_ACT;
         end
         S_ACT: begin
            cmd.phase = jadt_pkg::PH_ACT;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.phase = jadt_pkg::PH_EMIT;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### hdl/jadt_datapath.sv
// jadt_datapath: slot table, counters, scan capture, decision and response word
// depends on jadt_pkg and the channel interfaces in jadt_chan_if
module jadt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  jadt_pkg::ctl_cmd_type           cmd,
   output jadt_pkg::ctl_stat_type          stat,
   jadt_req_if.sink                        req_port,
   jadt_rsp_if.source                      rsp_port,
   input  logic                            csr_we,
   input  logic [jadt_pkg::CFG_BITS-1:0]   csr_index,
   input  logic [31:0]                     csr_wdata
);

   localparam int SB = jadt_pkg::SLOT_BITS;
   localparam int IB = jadt_pkg::IDENT_BITS;
   localparam int CB = jadt_pkg::CNT_BITS;

   // slot table
   logic          used_ff   [jadt_pkg::SLOTS];
   logic          owner_ff  [jadt_pkg::SLOTS];
   logic [IB-1:0] ident_ff  [jadt_pkg::SLOTS];
   logic [3:0]    jstate_ff [jadt_pkg::SLOTS];
   logic          cancel_ff [jadt_pkg::SLOTS];
   logic [10:0]   opm_ff    [jadt_pkg::SLOTS];
   logic [31:0]   key_ff    [jadt_pkg::SLOTS];
   logic [31:0]   dig_ff    [jadt_pkg::SLOTS];
   logic [31:0]   due_ff    [jadt_pkg::SLOTS];
   logic          hasout_ff [jadt_pkg::SLOTS];

   // configuration and counters
   logic [CB-1:0] run_limit_ff, wait_limit_ff, lim;
   logic [31:0]   timeout_ff;
   logic [CB-1:0] wait_cnt_ff, run_cnt_ff;
   logic [IB-1:0] next_id_ff;

   // latched request
   logic [2:0]  rq_type_ff;
   logic [31:0] rq_now_ff, rq_key_ff, rq_dig_ff, rq_due_ff;
   logic [15:0] rq_tgt_ff;
   logic [7:0]  rq_op_ff;
   logic [1:0]  rq_mode_ff;
   logic        rq_iso_ff;
   logic [3:0]  rq_out_ff;
   logic        disp_ok_ff;

   // scan capture
   logic          fnd_ff, fre_ff, own_ff, min_ff;
   logic [SB-1:0] fnd_idx_ff, fre_idx_ff, own_idx_ff, min_idx_ff;
   logic [3:0]    fnd_state_ff;
   logic          fnd_cancel_ff, fnd_hasout_ff, own_queued_ff, own_digeq_ff;
   logic [IB-1:0] min_ident_ff;
   logic [31:0]   due_eff_ff;
   logic          late_ff;

   // decision
   logic [2:0]    rc_ff, rc_in;
   logic          plan_owner_ff, plan_create_ff, plan_act_ff, job_ff;
   logic          own_in, cre_in, act_in, job_in;
   logic [SB-1:0] tgt_idx_ff, tgt_in;

   // response word
   logic        rsp_valid_ff;
   logic [2:0]  rsp_code_ff;
   logic [15:0] rsp_ident_ff;
   logic [3:0]  rsp_state_ff;
   logic        rsp_cancel_ff;
   logic [7:0]  rsp_op_ff;
   logic [31:0] rsp_key_ff, rsp_dig_ff, rsp_due_ff;

   // table read at the single working address
   logic [SB-1:0] addr;
   logic          rd_used, rd_owner, rd_cancel, rd_hasout, rd_term;
   logic [IB-1:0] rd_ident;
   logic [3:0]    rd_state;
   logic [10:0]   rd_opm;
   logic [31:0]   rd_key, rd_dig, rd_due;

   always_comb begin
      case (cmd.phase)
         jadt_pkg::PH_SCAN:   addr = cmd.scan_idx;
         jadt_pkg::PH_OWNER:  addr = own_idx_ff;
         jadt_pkg::PH_CREATE: addr = fre_idx_ff;
         default:             addr = tgt_idx_ff;
      endcase
   end

   assign rd_used   = used_ff[addr];
   assign rd_owner  = owner_ff[addr];
   assign rd_ident  = ident_ff[addr];
   assign rd_state  = jstate_ff[addr];
   assign rd_cancel = cancel_ff[addr];
   assign rd_opm    = opm_ff[addr];
   assign rd_key    = key_ff[addr];
   assign rd_dig    = dig_ff[addr];
   assign rd_due    = due_ff[addr];
   assign rd_hasout = hasout_ff[addr];
   assign rd_term   = jadt_pkg::is_terminal(rd_state);

   assign lim = (wait_limit_ff > CB'(jadt_pkg::WAIT_DEPTH)) ? CB'(jadt_pkg::WAIT_DEPTH)
                                                          : wait_limit_ff;

   // default deadline with saturation
   logic [32:0] due_sum;
   logic [31:0] due_eff;
   assign due_sum = {1'b0, rq_now_ff} + {1'b0, timeout_ff};
   assign due_eff = (rq_due_ff != 32'd0) ? rq_due_ff
                  : (due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0]);

   // per slot scan hits
   logic scan, do_expire, expiring, hit_fnd, hit_fre, hit_own, hit_min, first;
   assign scan      = (cmd.phase == jadt_pkg::PH_SCAN);
   assign first     = (cmd.scan_idx == '0);
   assign do_expire = (rq_type_ff == jadt_pkg::REQ_TICK) ||
                      ((rq_type_ff == jadt_pkg::REQ_DISPATCH) && disp_ok_ff);
   assign expiring  = scan && do_expire && rd_used && !rd_term && (rd_due <= rq_now_ff);
   assign hit_fnd   = rd_used && (rq_tgt_ff != 16'd0) && (rd_ident == rq_tgt_ff);
   assign hit_fre   = !rd_used;
   assign hit_own   = rd_used && rd_owner && (rd_opm[7:0] == rq_op_ff) &&
                      (rd_key == rq_key_ff) && !rd_term;
   assign hit_min   = rd_used && (rd_state == jadt_pkg::ST_QUEUED) && !expiring;

   logic fnd_prev, fre_prev, own_prev, min_prev;
   assign fnd_prev = !first && fnd_ff;
   assign fre_prev = !first && fre_ff;
   assign own_prev = !first && own_ff;
   assign min_prev = !first && min_ff;

   // decision from the scan results
   logic sub_inv, sup, own_hit;
   logic [CB-1:0] wc_eff;
   assign sub_inv = (rq_op_ff == 8'd0) || !rq_iso_ff || (rq_mode_ff == jadt_pkg::MODE_BAD) ||
                    ((rq_mode_ff != jadt_pkg::MODE_NONE) && (rq_key_ff == 32'd0));
   assign own_hit = (rq_mode_ff != jadt_pkg::MODE_NONE) && own_ff;
   assign sup     = own_hit && (rq_mode_ff == jadt_pkg::MODE_SUPER);
   assign wc_eff  = wait_cnt_ff - CB'(sup && own_queued_ff);

   always_comb begin
      rc_in  = jadt_pkg::RC_OK;
      own_in = 1'b0;
      cre_in = 1'b0;
      act_in = 1'b0;
      job_in = 1'b0;
      tgt_in = fnd_idx_ff;
      unique case (rq_type_ff)
         jadt_pkg::REQ_SUBMIT: begin
            tgt_in = fre_idx_ff;
            if (sub_inv) rc_in = jadt_pkg::RC_INVALID;
            else if (late_ff) begin
               if (next_id_ff == '0) rc_in = jadt_pkg::RC_IDS_OUT;
               else if (!fre_ff) rc_in = jadt_pkg::RC_TABLE_FULL;
               else begin
                  cre_in = 1'b1;
                  job_in = 1'b1;
               end
            end else if (own_hit && (rq_mode_ff == jadt_pkg::MODE_JOIN)) begin
               if (!own_digeq_ff) rc_in = jadt_pkg::RC_MISMATCH;
               else begin
                  tgt_in = own_idx_ff;
                  job_in = 1'b1;
               end
            end else if (sup && !own_queued_ff && (wait_cnt_ff >= lim)) begin
               rc_in = jadt_pkg::RC_WAIT_FULL;
            end else begin
               own_in = sup;
               if (wc_eff >= lim) rc_in = jadt_pkg::RC_WAIT_FULL;
               else if (next_id_ff == '0) rc_in = jadt_pkg::RC_IDS_OUT;
               else if (!fre_ff) rc_in = jadt_pkg::RC_TABLE_FULL;
               else begin
                  cre_in = 1'b1;
                  job_in = 1'b1;
               end
            end
         end
         jadt_pkg::REQ_CANCEL: begin
            if (!fnd_ff || jadt_pkg::is_terminal(fnd_state_ff) || fnd_cancel_ff)
               rc_in = jadt_pkg::RC_REFUSED;
            else begin
               act_in = 1'b1;
               job_in = 1'b1;
            end
         end
         jadt_pkg::REQ_DISPATCH: begin
            tgt_in = min_idx_ff;
            if (!disp_ok_ff || !min_ff) rc_in = jadt_pkg::RC_REFUSED;
            else begin
               act_in = 1'b1;
               job_in = 1'b1;
            end
         end
         jadt_pkg::REQ_FINISH: begin
            if (!jadt_pkg::is_terminal(rq_out_ff)) rc_in = jadt_pkg::RC_INVALID;
            else if (!fnd_ff || jadt_pkg::is_terminal(fnd_state_ff) ||
                     (fnd_state_ff == jadt_pkg::ST_QUEUED))
               rc_in = jadt_pkg::RC_REFUSED;
            else begin
               act_in = 1'b1;
               job_in = 1'b1;
            end
         end
         jadt_pkg::REQ_TAKE: begin
            if (!fnd_ff || !fnd_hasout_ff) rc_in = jadt_pkg::RC_REFUSED;
            else job_in = 1'b1;
         end
         jadt_pkg::REQ_STATUS: begin
            if (!fnd_ff) rc_in = jadt_pkg::RC_REFUSED;
            else job_in = 1'b1;
         end
         jadt_pkg::REQ_TICK: rc_in = jadt_pkg::RC_OK;
         default: rc_in = jadt_pkg::RC_INVALID;
      endcase
   end

   // table write commands at the working address
   logic        we_used, w_used, we_state, we_cancel, w_cancel, we_hasout, w_hasout;
   logic        we_owner, w_owner, we_fill;
   logic [3:0]  w_state;
   logic        wc_inc, wc_dec, run_inc, run_dec;
   logic        emit, take_clear;

   assign emit       = (cmd.phase == jadt_pkg::PH_EMIT);
   assign take_clear = emit && (rc_ff == jadt_pkg::RC_OK) && (rq_type_ff == jadt_pkg::REQ_TAKE);

   always_comb begin
      we_used = 1'b0;  w_used = 1'b0;
      we_state = 1'b0; w_state = jadt_pkg::ST_QUEUED;
      we_cancel = 1'b0; w_cancel = 1'b0;
      we_hasout = 1'b0; w_hasout = 1'b0;
      we_owner = 1'b0; w_owner = 1'b0;
      we_fill = 1'b0;
      wc_inc = 1'b0; wc_dec = 1'b0; run_inc = 1'b0; run_dec = 1'b0;
      case (cmd.phase)
         jadt_pkg::PH_SCAN: begin
            if (expiring) begin
               we_cancel = 1'b1; w_cancel = 1'b1;
               we_state = 1'b1;  w_state = jadt_pkg::ST_DEADLINE;
               we_hasout = 1'b1; w_hasout = 1'b1;
               we_owner = 1'b1;
               if (rd_state == jadt_pkg::ST_QUEUED) wc_dec = 1'b1;
               else run_dec = 1'b1;
            end
         end
         jadt_pkg::PH_OWNER, jadt_pkg::PH_ACT: begin
            // supersede of the key owner or a plain cancel share one path
            if ((cmd.phase == jadt_pkg::PH_OWNER && plan_owner_ff) ||
                (cmd.phase == jadt_pkg::PH_ACT && plan_act_ff &&
                 rq_type_ff == jadt_pkg::REQ_CANCEL)) begin
               we_cancel = 1'b1; w_cancel = 1'b1;
               we_state = 1'b1;
               if (rd_state == jadt_pkg::ST_QUEUED) begin
                  w_state = jadt_pkg::ST_CANCELLED;
                  we_hasout = 1'b1; w_hasout = 1'b1;
                  we_owner = 1'b1;
                  wc_dec = 1'b1;
               end else begin
                  w_state = jadt_pkg::ST_CANCELLING;
                  we_owner = (cmd.phase == jadt_pkg::PH_OWNER) && plan_create_ff;
               end
            end else if (cmd.phase == jadt_pkg::PH_ACT && plan_act_ff &&
                         rq_type_ff == jadt_pkg::REQ_DISPATCH) begin
               we_state = 1'b1; w_state = jadt_pkg::ST_RUNNING;
               run_inc = 1'b1;
               wc_dec = 1'b1;
            end else if (cmd.phase == jadt_pkg::PH_ACT && plan_act_ff &&
                         rq_type_ff == jadt_pkg::REQ_FINISH) begin
               we_state = 1'b1;
               w_state = rd_cancel ? jadt_pkg::ST_CANCELLED : rq_out_ff;
               we_hasout = 1'b1; w_hasout = 1'b1;
               we_owner = 1'b1;
               run_dec = 1'b1;
            end
         end
         jadt_pkg::PH_CREATE: begin
            if (plan_create_ff) begin
               we_used = 1'b1;   w_used = 1'b1;
               we_fill = 1'b1;
               we_state = 1'b1;
               w_state = late_ff ? jadt_pkg::ST_DEADLINE : jadt_pkg::ST_QUEUED;
               we_cancel = 1'b1;
               we_hasout = 1'b1; w_hasout = late_ff;
               we_owner = 1'b1;
               w_owner = !late_ff && (rq_mode_ff != jadt_pkg::MODE_NONE);
               wc_inc = !late_ff;
            end
         end
         jadt_pkg::PH_EMIT: begin
            if (take_clear && stat.rsp_free) begin
               we_used = 1'b1;
               we_owner = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // slot storage, flags with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < jadt_pkg::SLOTS; i++) begin
            used_ff[i]  <= 1'b0;
            owner_ff[i] <= 1'b0;
         end
      end else begin
         if (we_used)  used_ff[addr]  <= w_used;
         if (we_owner) owner_ff[addr] <= w_owner;
      end
   end

   // slot storage, payload
   always_ff @(posedge clock) begin
      if (we_state)  jstate_ff[addr] <= w_state;
      if (we_cancel) cancel_ff[addr] <= w_cancel;
      if (we_hasout) hasout_ff[addr] <= w_hasout;
      if (we_fill) begin
         ident_ff[addr] <= next_id_ff;
         opm_ff[addr]   <= {1'b1, rq_mode_ff, rq_op_ff};
         key_ff[addr]   <= rq_key_ff;
         dig_ff[addr]   <= rq_dig_ff;
         due_ff[addr]   <= due_eff_ff;
      end
   end

   // configuration, counters and identity source
   always_ff @(posedge clock) begin
      if (reset) begin
         run_limit_ff  <= jadt_pkg::RST_RUN_LIMIT;
         wait_limit_ff <= jadt_pkg::RST_WAIT_LIMIT;
         timeout_ff    <= jadt_pkg::RST_TIMEOUT;
         wait_cnt_ff   <= '0;
         run_cnt_ff    <= '0;
         next_id_ff    <= IB'(1);
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               jadt_pkg::CSR_RUN_LIMIT:  run_limit_ff  <= csr_wdata[CB-1:0];
               jadt_pkg::CSR_WAIT_LIMIT: wait_limit_ff <= csr_wdata[CB-1:0];
               jadt_pkg::CSR_TIMEOUT:    timeout_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (wc_inc) wait_cnt_ff <= wait_cnt_ff + 1'b1;
         else if (wc_dec) wait_cnt_ff <= wait_cnt_ff - 1'b1;
         if (run_inc) run_cnt_ff <= run_cnt_ff + 1'b1;
         else if (run_dec && run_cnt_ff != '0) run_cnt_ff <= run_cnt_ff - 1'b1;
         if (we_fill) next_id_ff <= next_id_ff + 1'b1;
      end
   end

   // request latch, scan capture and plan
   always_ff @(posedge clock) begin
      if (reset) begin
         plan_owner_ff  <= 1'b0;
         plan_create_ff <= 1'b0;
         plan_act_ff    <= 1'b0;
      end else if (cmd.phase == jadt_pkg::PH_DECIDE) begin
         plan_owner_ff  <= own_in;
         plan_create_ff <= cre_in;
         plan_act_ff    <= act_in;
      end
      if (cmd.phase == jadt_pkg::PH_LOAD) begin
         rq_type_ff <= req_port.req_type;
         rq_now_ff  <= req_port.now_time;
         rq_tgt_ff  <= req_port.target_ident;
         rq_op_ff   <= req_port.op_code;
         rq_mode_ff <= req_port.merge_mode;
         rq_key_ff  <= req_port.merge_key;
         rq_dig_ff  <= req_port.data_digest;
         rq_iso_ff  <= req_port.isolated_ok;
         rq_due_ff  <= req_port.due_time;
         rq_out_ff  <= req_port.worker_outcome;
         disp_ok_ff <= (run_cnt_ff < run_limit_ff);
      end
      if (scan) begin
         due_eff_ff <= due_eff;
         late_ff    <= (due_eff <= rq_now_ff);
         fnd_ff <= fnd_prev || hit_fnd;
         if (hit_fnd && !fnd_prev) begin
            fnd_idx_ff    <= cmd.scan_idx;
            fnd_state_ff  <= rd_state;
            fnd_cancel_ff <= rd_cancel;
            fnd_hasout_ff <= rd_hasout;
         end
         fre_ff <= fre_prev || hit_fre;
         if (hit_fre && !fre_prev) fre_idx_ff <= cmd.scan_idx;
         own_ff <= own_prev || hit_own;
         if (hit_own && !own_prev) begin
            own_idx_ff    <= cmd.scan_idx;
            own_queued_ff <= (rd_state == jadt_pkg::ST_QUEUED);
            own_digeq_ff  <= (rd_dig == rq_dig_ff);
         end
         min_ff <= min_prev || hit_min;
         if (hit_min && (!min_prev || rd_ident < min_ident_ff)) begin
            min_idx_ff   <= cmd.scan_idx;
            min_ident_ff <= rd_ident;
         end
      end
      if (cmd.phase == jadt_pkg::PH_DECIDE) begin
         rc_ff      <= rc_in;
         job_ff     <= job_in;
         tgt_idx_ff <= tgt_in;
      end
   end

   // response word register
   assign stat.rsp_free = !rsp_valid_ff || rsp_port.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && stat.rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit && stat.rsp_free) begin
         rsp_code_ff <= rc_ff;
         if (rc_ff == jadt_pkg::RC_OK && job_ff) begin
            rsp_ident_ff  <= 16'(rd_ident);
            rsp_state_ff  <= rd_state;
            rsp_cancel_ff <= rd_cancel;
            rsp_op_ff     <= rd_opm[7:0];
            rsp_due_ff    <= rd_due;
         end else begin
            rsp_ident_ff  <= '0;
            rsp_state_ff  <= '0;
            rsp_cancel_ff <= 1'b0;
            rsp_op_ff     <= '0;
            rsp_due_ff    <= '0;
         end
         if (rc_ff == jadt_pkg::RC_OK && job_ff && rq_type_ff == jadt_pkg::REQ_DISPATCH) begin
            rsp_key_ff <= rd_key;
            rsp_dig_ff <= rd_dig;
         end else begin
            rsp_key_ff <= '0;
            rsp_dig_ff <= '0;
         end
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status_code   = rsp_code_ff;
   assign rsp_port.result_ident  = rsp_ident_ff;
   assign rsp_port.job_state     = rsp_state_ff;
   assign rsp_port.cancel_flag   = rsp_cancel_ff;
   assign rsp_port.out_op_code   = rsp_op_ff;
   assign rsp_port.out_merge_key = rsp_key_ff;
   assign rsp_port.out_digest    = rsp_dig_ff;
   assign rsp_port.out_due_time  = rsp_due_ff;

   // checks
   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      wait_cnt_ff <= CB'(jadt_pkg::WAIT_DEPTH))
      else $error("wait count beyond queue depth");

   a_ident_live: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == jadt_pkg::PH_CREATE && plan_create_ff) |-> next_id_ff != '0)
      else $error("job created with exhausted identity");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (emit && stat.rsp_free && rc_ff != jadt_pkg::RC_OK) |=>
      (rsp_ident_ff == '0 && rsp_state_ff == '0 && rsp_due_ff == '0))
      else $error("error answer carries job fields");

endmodule

### hdl/job_admission_dispatch_table.sv
// job_admission_dispatch_table: top level of the job table
// sequence: after a request is accepted it passes through the slot scan, decide, owner,
//   create, act and emit steps; emit waits while the response word is stalled
// a new request is accepted only once the last one has emitted its response word;
//   the table scan that dominates this sequence reads one slot per cycle
// reset: synchronous, clears the table, counters and limits to their defaults
module job_admission_dispatch_table (
   input  logic                          clock,
   input  logic                          reset,
   jadt_req_if.sink                      req_port,
   jadt_rsp_if.source                    rsp_port,
   input  logic                          csr_we,
   input  logic [jadt_pkg::CFG_BITS-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   jadt_pkg::ctl_cmd_type  cmd;
   jadt_pkg::ctl_stat_type stat;
   logic                   ready;

   // sequencer
   jadt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_port.ready = ready;

   // table and response word
   jadt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
